@@ rtl/calibrated_odometer_accumulator_top_assert.svh @@
// Assertion macros for the odometer accumulator checker
`ifndef CALIBRATED_ODOMETER_ACCUMULATOR_TOP_ASSERT_SVH
`define CALIBRATED_ODOMETER_ACCUMULATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, idle during reset
`define COA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define COA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/coa_pkg.sv @@
// Shared types, constants and helpers of the odometer accumulator
package coa_pkg;

	localparam int DIV_W = 30;
	localparam int CNT_W = $clog2(DIV_W);

	localparam logic signed [32:0] NANO     = 33'sd1000000000;
	localparam logic signed [32:0] TWO_NANO = 33'sd2000000000;
	localparam logic signed [32:0] NEG_NANO = -33'sd1000000000;
	localparam logic signed [32:0] NEG_TWO_NANO = -33'sd2000000000;
	localparam logic signed [32:0] TOTAL_MAX = 33'sd2147483647;
	localparam logic signed [32:0] TOTAL_MIN = -33'sd2147483648;

	typedef enum logic [1:0] {
		REG_PULSE_DISTANCE = 2'd0,
		REG_OFFICIAL_TRIP  = 2'd1,
		REG_SELF_TRIP      = 2'd2,
		REG_TRIP_MODE      = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_PULSE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_IGNORE = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_SUB    = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		MODE_NEUTRAL = 2'd0,
		MODE_FORWARD = 2'd1,
		MODE_REVERSE = 2'd2
	} mode_t;

	// controls from the sequencer to the accumulator datapath
	typedef struct packed {
		logic sum_en;
		logic add;
		logic sub;
		logic carry_en;
		logic sat_en;
		logic clear;
	} coa_acc_ctl_t;

	function automatic act_t dir_action(logic [1:0] mode, logic rev);
		act_t a;
		case (mode)
			MODE_FORWARD: a = rev ? ACT_SUB : ACT_ADD;
			MODE_REVERSE: a = rev ? ACT_ADD : ACT_SUB;
			default:      a = ACT_IGNORE;
		endcase
		return a;
	endfunction

endpackage

@@ rtl/coa_div.sv @@
// Shared restoring divider, one quotient bit per cycle
module coa_div import coa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_diff;
	logic             fits;

	assign rem_sh   = {rem_q, dvd_q[DIV_W-1]};
	assign rem_diff = rem_sh - {1'b0, dsr_q};
	assign fits     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(DIV_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// dividend register shifts out its bits and fills with quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ rtl/coa_accum.sv @@
// Fraction accumulator with whole-unit carry and saturating total
module coa_accum import coa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  coa_acc_ctl_t       ctl,
	input  logic [DIV_W-1:0]   step,
	output logic signed [31:0] total
);

	logic signed [31:0] frac_q;
	logic signed [31:0] total_q;
	logic signed [32:0] sum_q;
	logic signed [2:0]  carry_q;

	logic signed [32:0] step_ext;
	logic signed [32:0] frac_ext;
	logic signed [32:0] sum_nxt;
	logic signed [32:0] rem;
	logic signed [2:0]  carry;
	logic signed [32:0] tot_ext;

	assign step_ext = signed'({3'b000, step});
	assign frac_ext = {frac_q[31], frac_q};

	always_comb begin
		if (ctl.add)
			sum_nxt = frac_ext + step_ext;
		else if (ctl.sub)
			sum_nxt = frac_ext - step_ext;
		else
			sum_nxt = frac_ext;
	end

	// truncating quotient and remainder by one unit; |sum| stays below 3 units
	always_comb begin
		if (sum_q >= TWO_NANO) begin
			carry = 3'sd2;
			rem   = sum_q - TWO_NANO;
		end else if (sum_q >= NANO) begin
			carry = 3'sd1;
			rem   = sum_q - NANO;
		end else if (sum_q <= NEG_TWO_NANO) begin
			carry = -3'sd2;
			rem   = sum_q + TWO_NANO;
		end else if (sum_q <= NEG_NANO) begin
			carry = -3'sd1;
			rem   = sum_q + NANO;
		end else begin
			carry = 3'sd0;
			rem   = sum_q;
		end
	end

	assign tot_ext = {total_q[31], total_q} + {{30{carry_q[2]}}, carry_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q  <= '0;
			total_q <= '0;
		end else begin
			if (ctl.carry_en)
				frac_q <= rem[31:0];
			if (ctl.clear)
				total_q <= '0;
			else if (ctl.sat_en) begin
				if (tot_ext > TOTAL_MAX)
					total_q <= TOTAL_MAX[31:0];
				else if (tot_ext < TOTAL_MIN)
					total_q <= TOTAL_MIN[31:0];
				else
					total_q <= tot_ext[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en)
			sum_q <= sum_nxt;
		if (ctl.carry_en)
			carry_q <= carry;
	end

	assign total = total_q;

endmodule

@@ rtl/calibrated_odometer_accumulator_top.sv @@
// A read request loads its result when accepted, later if the output stalls.
// A pulse request keeps the block busy for setup, the shared one-bit-per-cycle divider,
// a hand-off, then add, carry and saturate; a zero divisor returns it to idle after setup.
// A write to official_trip or self_trip busies the block for a divisor recompute.
// Reset (arst_n low, async): registers and state to defaults, divisor 1, output empty.
module calibrated_odometer_accumulator_top import coa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [0] reverse_switch, [7:1] zero
	input  logic               s_tuser,   // [0] command
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [31:0] m_tdata,   // [31:0] whole_distance
	output logic               m_tuser,   // [0] calib_fault
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [DIV_W-1:0]   cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_CDIV  = 8'b0000_0010,
		S_PGO   = 8'b0000_0100,
		S_PDIV  = 8'b0000_1000,
		S_ACC   = 8'b0001_0000,
		S_CARRY = 8'b0010_0000,
		S_SAT   = 8'b0100_0000,
		S_ROUT  = 8'b1000_0000
	} state_t;

	state_t             state_q, state_nxt;
	logic [DIV_W-1:0]   pulse_distance_q;
	logic [DIV_W-1:0]   official_trip_q;
	logic [DIV_W-1:0]   self_trip_q;
	logic [1:0]         mode_q;
	logic [DIV_W-1:0]   calib_q;
	logic               pend_q;
	logic               rev_q;
	act_t               act_q;
	logic               m_tvalid_q;
	logic signed [31:0] m_tdata_q;
	logic               m_tuser_q;

	logic               cfg_recalc;
	logic               in_acc;
	logic               out_free;
	logic               load_out;
	logic               start_cfg;
	logic               div_start;
	logic [DIV_W-1:0]   div_a;
	logic [DIV_W-1:0]   div_b;
	logic               div_done;
	logic [DIV_W-1:0]   div_q;
	coa_acc_ctl_t       acc_ctl;
	logic signed [31:0] total;

	assign cfg_recalc = cfg_wr_en && (cfg_index == REG_OFFICIAL_TRIP ||
		cfg_index == REG_SELF_TRIP);
	assign s_tready   = (state_q == S_IDLE) && !pend_q && !cfg_recalc;
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		div_start = 1'b0;
		start_cfg = 1'b0;
		load_out  = 1'b0;
		acc_ctl   = '0;
		div_a     = pulse_distance_q;
		div_b     = calib_q;
		case (state_q)
			S_IDLE: begin
				div_a = official_trip_q;
				div_b = self_trip_q;
				if (pend_q) begin
					div_start = 1'b1;
					start_cfg = 1'b1;
					state_nxt = S_CDIV;
				end else if (in_acc) begin
					if (s_tuser == CMD_READ) begin
						if (out_free) begin
							load_out      = 1'b1;
							acc_ctl.clear = 1'b1;
						end else
							state_nxt = S_ROUT;
					end else
						state_nxt = S_PGO;
				end
			end
			S_CDIV: begin
				if (div_done)
					state_nxt = S_IDLE;
			end
			S_PGO: begin
				if (calib_q == '0)
					state_nxt = S_IDLE;
				else begin
					div_start = 1'b1;
					state_nxt = S_PDIV;
				end
			end
			S_PDIV: begin
				if (div_done)
					state_nxt = S_ACC;
			end
			S_ACC: begin
				acc_ctl.sum_en = 1'b1;
				acc_ctl.add    = (act_q == ACT_ADD);
				acc_ctl.sub    = (act_q == ACT_SUB);
				state_nxt      = S_CARRY;
			end
			S_CARRY: begin
				acc_ctl.carry_en = 1'b1;
				state_nxt        = S_SAT;
			end
			S_SAT: begin
				acc_ctl.sat_en = 1'b1;
				state_nxt      = S_IDLE;
			end
			S_ROUT: begin
				if (out_free) begin
					load_out      = 1'b1;
					acc_ctl.clear = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			pulse_distance_q <= '0;
			official_trip_q  <= DIV_W'(1);
			self_trip_q      <= DIV_W'(1);
			mode_q           <= MODE_NEUTRAL;
			calib_q          <= DIV_W'(1);
			pend_q           <= 1'b0;
			m_tvalid_q       <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PULSE_DISTANCE: pulse_distance_q <= cfg_data;
					REG_OFFICIAL_TRIP:  official_trip_q  <= cfg_data;
					REG_SELF_TRIP:      self_trip_q      <= cfg_data;
					REG_TRIP_MODE:      mode_q           <= cfg_data[1:0];
					default: ;
				endcase
			end
			// a later write queues another recompute after the current one
			if (cfg_recalc)
				pend_q <= 1'b1;
			else if (start_cfg)
				pend_q <= 1'b0;
			if (state_q == S_CDIV && div_done)
				calib_q <= (self_trip_q == '0) ? '0 : div_q;
			if (load_out)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			rev_q <= s_tdata[0];
		if (state_q == S_PGO)
			act_q <= dir_action(mode_q, rev_q);
		if (load_out) begin
			m_tdata_q <= total;
			m_tuser_q <= (calib_q == '0);
		end
	end

	coa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	coa_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.step   (div_q),
		.total  (total)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/coa_checker.sv @@
// Port-level checker for the odometer accumulator, bound to the top level
`include "calibrated_odometer_accumulator_top_assert.svh"

module coa_checker import coa_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [7:0]         s_tdata,
	input logic               s_tuser,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic signed [31:0] m_tdata,
	input logic               m_tuser,
	input logic               cfg_wr_en,
	input logic [1:0]         cfg_index,
	input logic [DIV_W-1:0]   cfg_data
);

	logic pulse_acc;
	logic recalc_wr;

	assign pulse_acc = s_tvalid && s_tready && (s_tuser == CMD_PULSE);
	assign recalc_wr = cfg_wr_en && (cfg_index == REG_OFFICIAL_TRIP ||
		cfg_index == REG_SELF_TRIP);

	// a pulse never makes a result
	`COA_ASSERT_NEXT(a_pulse_no_result, pulse_acc, !$rose(m_tvalid), "result after pulse")
	// a pulse occupies the block for its divide
	`COA_ASSERT_NEXT(a_pulse_busy, pulse_acc, !s_tready, "ready right after pulse")
	// divisor recompute blocks new requests
	`COA_ASSERT_NOW(a_recalc_blocks, recalc_wr, !s_tready, "ready during divisor write")
	`COA_ASSERT_NEXT(a_recalc_busy, recalc_wr, !s_tready, "ready after divisor write")
	// stalled result holds
	`COA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind calibrated_odometer_accumulator_top coa_checker u_coa_checker (.*);
